// ----- rtl/core/kfus_pkg.sv -----
// ----------------------------------------------------------------------------
// kfus_pkg: shared definitions for the two-sensor altitude Kalman fusion
// Fixed-point widths, register indexes, sequencer states and unit status.
// ----------------------------------------------------------------------------
package kfus_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int FRAC_BITS    = 16;
  localparam int CFG_WIDTH    = FRAC_BITS + 8;
  localparam int VAR_WIDTH    = FRAC_BITS + 9;
  localparam int DEN_WIDTH    = VAR_WIDTH + 1;
  localparam int INNOV_WIDTH  = SAMPLE_WIDTH + 1;
  localparam int CORR_WIDTH   = INNOV_WIDTH + 1;
  localparam int MUL_A_WIDTH  = (INNOV_WIDTH > VAR_WIDTH) ? INNOV_WIDTH : VAR_WIDTH;
  localparam int MUL_B_WIDTH  = FRAC_BITS + 1;
  localparam int PROD_WIDTH   = MUL_A_WIDTH + MUL_B_WIDTH;
  localparam int STEP_CNT_WIDTH = $clog2(FRAC_BITS);
  localparam int CFG_IDX_WIDTH  = 2;

  localparam logic [MUL_B_WIDTH-1:0] GAIN_ONE = MUL_B_WIDTH'(1) << FRAC_BITS;

  localparam logic [CFG_WIDTH-1:0] PROCESS_VAR_RST = CFG_WIDTH'(655);
  localparam logic [CFG_WIDTH-1:0] GPS_VAR_RST     = CFG_WIDTH'(65536);
  localparam logic [CFG_WIDTH-1:0] PROX_VAR_RST    = CFG_WIDTH'(1638400);

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_PROCESS_VAR = 2'd0,
    REG_GPS_VAR     = 2'd1,
    REG_PROX_VAR    = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREDICT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL_EST,
    ST_UPD_EST,
    ST_UPD_VAR,
    ST_DONE
  } kfus_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/core/kfus_if.sv -----
// ----------------------------------------------------------------------------
// kfus_if: valid/ready channels of the altitude fusion block
// Sample input, fused result output and register write channel.
// ----------------------------------------------------------------------------
interface kfus_sample_if import kfus_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] gps_altitude;
  logic signed [SAMPLE_WIDTH-1:0] prox_altitude;

  modport source (output valid, gps_altitude, prox_altitude, input ready);
  modport sink   (input valid, gps_altitude, prox_altitude, output ready);
endinterface

interface kfus_result_if import kfus_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] altitude_estimate;
  logic        [VAR_WIDTH-1:0]    estimate_variance;

  modport source (output valid, altitude_estimate, estimate_variance, input ready);
  modport sink   (input valid, altitude_estimate, estimate_variance, output ready);
endinterface

interface kfus_cfg_if import kfus_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_WIDTH-1:0] index;
  logic [CFG_WIDTH-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/kfus_div.sv -----
// ----------------------------------------------------------------------------
// kfus_div: shift-subtract gain divider
// Gain = floor(P * 2^F / (P + R)), one quotient bit per cycle; all ones if only R is 0.
// ----------------------------------------------------------------------------
module kfus_div import kfus_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VAR_WIDTH-1:0]  p,
  input  logic [CFG_WIDTH-1:0]  r,
  output div_stat_t             stat,
  output logic [FRAC_BITS-1:0]  quot
);

  logic                      busy;
  logic                      done;
  logic [STEP_CNT_WIDTH-1:0] cnt;
  logic [DEN_WIDTH-1:0]      rem;
  logic [DEN_WIDTH-1:0]      den;
  logic [DEN_WIDTH:0]        rem2;
  logic [DEN_WIDTH:0]        diff;
  logic                      last;

  assign rem2 = {rem, 1'b0};
  assign diff = rem2 - {1'b0, den};
  assign last = (cnt == STEP_CNT_WIDTH'(FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // zero noise: gain saturates, or stays zero when P is zero too
        if (r == '0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den  <= DEN_WIDTH'(p) + DEN_WIDTH'(r);
      rem  <= DEN_WIDTH'(p);
      cnt  <= '0;
      quot <= (r == '0 && p != '0) ? '1 : '0;
    end else if (busy) begin
      cnt <= cnt + STEP_CNT_WIDTH'(1);
      if (!diff[DEN_WIDTH]) begin
        rem  <= diff[DEN_WIDTH-1:0];
        quot <= {quot[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem  <= rem2[DEN_WIDTH-1:0];
        quot <= {quot[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_finish: assert property (@(posedge clk) disable iff (rst)
    busy && last && !start |=> done && !busy)
    else $error("divider did not finish after last step");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
`endif

endmodule

// ----- rtl/core/two_sensor_scalar_kalman_fusion.sv -----
// ----------------------------------------------------------------------------
// two_sensor_scalar_kalman_fusion: scalar Kalman altitude fusion, GPS + prox
// Predict, then GPS correction, then proximity correction per sample word.
// ----------------------------------------------------------------------------
// Usage:
//   samples : sink channel, one word = GPS and proximity altitude (Q15.16).
//   results : source channel, one word per sample = fused estimate (Q15.16)
//             and its variance (Q9.16).
//   cfg     : register writes, always ready; index 0 process_var, 1 gps_var,
//             2 prox_var; other indexes are ignored. Write only when idle.
//   The first word after reset seeds the estimate with the mean of both
//   samples and the variance with process_var.
//   Each word runs a predict step, then per sensor the divider start, 16
//   shift-subtract steps and the done strobe, then MUL_EST, UPD_EST and
//   UPD_VAR on the shared multiplier, then the output load. A zero noise
//   register skips the shift-subtract steps of its division.
//   One word is in work at a time; a new word is taken only in idle.
//   The result register holds a finished word while the receiver stalls;
//   the next sample is still accepted, but its result waits for the slot.
//   rst (synchronous) restores register defaults and clears the filter.
// ----------------------------------------------------------------------------
module two_sensor_scalar_kalman_fusion import kfus_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  kfus_sample_if.sink   samples,
  kfus_result_if.source results,
  kfus_cfg_if.sink      cfg
);

  kfus_state_t state, state_next;

  logic [CFG_WIDTH-1:0]           process_var;
  logic [CFG_WIDTH-1:0]           gps_var;
  logic [CFG_WIDTH-1:0]           prox_var;
  logic signed [SAMPLE_WIDTH-1:0] estimate;
  logic [VAR_WIDTH-1:0]           variance;
  logic                           started;
  logic signed [SAMPLE_WIDTH-1:0] gps_z;
  logic signed [SAMPLE_WIDTH-1:0] prox_z;
  logic                           second;
  logic                           innov_neg;
  logic [PROD_WIDTH-1:0]          prod;
  logic                           out_valid;
  logic signed [SAMPLE_WIDTH-1:0] out_est;
  logic [VAR_WIDTH-1:0]           out_var;

  logic                           div_start;
  div_stat_t                      div_stat;
  logic [FRAC_BITS-1:0]           gain;

  logic signed [SAMPLE_WIDTH-1:0] z;
  logic [CFG_WIDTH-1:0]           r;
  logic signed [INNOV_WIDTH-1:0]  innov;
  logic [INNOV_WIDTH-1:0]         innov_mag;
  logic signed [INNOV_WIDTH-1:0]  seed_sum;
  logic signed [INNOV_WIDTH-1:0]  seed_half;
  logic [VAR_WIDTH-1:0]           var_base;
  logic [VAR_WIDTH:0]             var_sum;
  logic [INNOV_WIDTH-1:0]         corr_q;
  logic                           corr_frac;
  logic signed [CORR_WIDTH-1:0]   corr_mag;
  logic signed [CORR_WIDTH-1:0]   corr;
  logic signed [CORR_WIDTH-1:0]   est_sum;
  logic [MUL_A_WIDTH-1:0]         mul_a;
  logic [MUL_B_WIDTH-1:0]         mul_b;
  logic                           out_load;

  kfus_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .p     (variance),
    .r     (r),
    .stat  (div_stat),
    .quot  (gain)
  );

  // register file
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_var <= PROCESS_VAR_RST;
      gps_var     <= GPS_VAR_RST;
      prox_var    <= PROX_VAR_RST;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_PROCESS_VAR: process_var <= cfg.data;
        REG_GPS_VAR:     gps_var     <= cfg.data;
        REG_PROX_VAR:    prox_var    <= cfg.data;
        default: ;
      endcase
    end
  end

  // datapath
  assign z = second ? prox_z : gps_z;
  assign r = second ? prox_var : gps_var;

  assign innov     = INNOV_WIDTH'(z) - INNOV_WIDTH'(estimate);
  assign innov_mag = innov[INNOV_WIDTH-1] ? INNOV_WIDTH'(-innov) : INNOV_WIDTH'(innov);

  assign seed_sum  = INNOV_WIDTH'(gps_z) + INNOV_WIDTH'(prox_z);
  assign seed_half = seed_sum >>> 1;

  assign var_base = started ? variance : VAR_WIDTH'(process_var);
  assign var_sum  = {1'b0, var_base} + (VAR_WIDTH + 1)'(process_var);

  assign corr_q    = prod[FRAC_BITS +: INNOV_WIDTH];
  assign corr_frac = |prod[FRAC_BITS-1:0];
  assign corr_mag  = {1'b0, corr_q};
  assign corr      = innov_neg ? (-corr_mag - CORR_WIDTH'(corr_frac)) : corr_mag;
  assign est_sum   = CORR_WIDTH'(estimate) + corr;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL_EST: begin
        mul_a = MUL_A_WIDTH'(innov_mag);
        mul_b = MUL_B_WIDTH'(gain);
      end
      ST_UPD_EST: begin
        mul_a = MUL_A_WIDTH'(variance);
        mul_b = GAIN_ONE - MUL_B_WIDTH'(gain);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      gps_z  <= samples.gps_altitude;
      prox_z <= samples.prox_altitude;
    end
    if (state == ST_MUL_EST) begin
      innov_neg <= innov[INNOV_WIDTH-1];
    end
    if (out_load) begin
      out_est <= estimate;
      out_var <= variance;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      estimate <= '0;
      variance <= '0;
      started  <= 1'b0;
      second   <= 1'b0;
    end else begin
      case (state)
        ST_PREDICT: begin
          started <= 1'b1;
          second  <= 1'b0;
          if (!started) begin
            estimate <= seed_half[SAMPLE_WIDTH-1:0];
          end
          variance <= var_sum[VAR_WIDTH] ? '1 : var_sum[VAR_WIDTH-1:0];
        end
        ST_UPD_EST: estimate <= est_sum[SAMPLE_WIDTH-1:0];
        ST_UPD_VAR: begin
          variance <= prod[FRAC_BITS +: VAR_WIDTH];
          second   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign results.valid             = out_valid;
  assign results.altitude_estimate = out_est;
  assign results.estimate_variance = out_var;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid) begin
          state_next = ST_PREDICT;
        end
      end
      ST_PREDICT: state_next = ST_DIV_GO;
      ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_MUL_EST;
        end
      end
      ST_MUL_EST: state_next = ST_UPD_EST;
      ST_UPD_EST: state_next = ST_UPD_VAR;
      ST_UPD_VAR: state_next = second ? ST_DONE : ST_DIV_GO;
      ST_DONE: begin
        if (!out_valid || results.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_div_to_mul: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV_WAIT && div_stat.done |=> state == ST_MUL_EST)
    else $error("gain ready but multiply not started");
  a_var_shrinks: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPD_VAR |=> variance <= $past(variance))
    else $error("correction grew the variance");
  a_started: assert property (@(posedge clk) disable iff (rst)
    state == ST_PREDICT |=> started)
    else $error("filter not marked started after predict");
`endif

endmodule

// ----- bench/two_sensor_scalar_kalman_fusion_tb.sv -----
// ----------------------------------------------------------------------------
// two_sensor_scalar_kalman_fusion_tb: self-checking bench for the fusion block
// Drives GPS/proximity sample words and register writes with random gaps,
// predicts every fused estimate and variance with a bit-exact fixed-point
// filter of its own, and checks each result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_sensor_scalar_kalman_fusion_tb;
  import kfus_pkg::*;

  localparam int      HALF_PERIOD = 4;
  localparam int      RESET_CYCLES = 5;
  localparam int      STALL_LIMIT = 4000;
  localparam int      SETTLE_CYCLES = 100;
  localparam int      GAP_PCT = 23;
  localparam int      PHASES = 9;
  localparam int      PHASE_WORDS = 100;
  localparam int      BURST_WORDS = 200;
  localparam int      MAX_REPORTS = 10;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED = 2'd3;

  localparam logic signed [SAMPLE_WIDTH-1:0] ALT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] ALT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [CFG_WIDTH-1:0]           NOISE_MAX = {CFG_WIDTH{1'b1}};
  localparam logic [63:0]                    GAIN_MAX = (64'd1 << FRAC_BITS) - 1;
  localparam logic [63:0]                    VAR_MAX = (64'd1 << VAR_WIDTH) - 1;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] altitude_estimate;
    logic [VAR_WIDTH-1:0]           estimate_variance;
  } fused_t;

  logic clk = 1'b0;
  logic rst;

  kfus_sample_if samp_if ();
  kfus_result_if res_if ();
  kfus_cfg_if    cfg_if ();

  two_sensor_scalar_kalman_fusion dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samp_if),
    .results (res_if),
    .cfg     (cfg_if)
  );

  // filter copy and register shadow
  logic [CFG_WIDTH-1:0] m_proc;
  logic [CFG_WIDTH-1:0] m_gps;
  logic [CFG_WIDTH-1:0] m_prox;
  logic signed [63:0]   m_est;
  logic [63:0]          m_var;
  bit                   m_started;

  fused_t fused_q[$];
  int     err_cnt = 0;
  int     stall_cnt = 0;
  bit     gaps_on = 1'b1;
  int     alt_track = 0;

  always #HALF_PERIOD clk = ~clk;

  task automatic report_fail(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  function automatic void kalman_correct(input logic signed [63:0] z,
                                         input logic [CFG_WIDTH-1:0] r);
    logic [63:0]        p;
    logic [63:0]        den;
    logic [63:0]        k;
    logic signed [63:0] innov;
    logic signed [63:0] prod;
    p = m_var;
    den = p + r;
    k = '0;
    if (den != 0) begin
      k = (p << FRAC_BITS) / den;
      if (k > GAIN_MAX) k = GAIN_MAX;
    end
    innov = z - m_est;
    prod = $signed(k) * innov;
    m_est = m_est + (prod >>> FRAC_BITS);
    m_var = (p * ((64'd1 << FRAC_BITS) - k)) >> FRAC_BITS;
  endfunction

  function automatic fused_t predict_fused(input logic signed [SAMPLE_WIDTH-1:0] g,
                                           input logic signed [SAMPLE_WIDTH-1:0] x);
    logic signed [63:0] zg;
    logic signed [63:0] zx;
    fused_t             res;
    zg = g;
    zx = x;
    if (!m_started) begin
      m_est = (zg + zx) >>> 1;
      m_var = m_proc;
      m_started = 1'b1;
    end
    m_var = m_var + m_proc;
    if (m_var > VAR_MAX) m_var = VAR_MAX;
    kalman_correct(zg, m_gps);
    kalman_correct(zx, m_prox);
    res.altitude_estimate = m_est[SAMPLE_WIDTH-1:0];
    res.estimate_variance = m_var[VAR_WIDTH-1:0];
    return res;
  endfunction

  // valid stays high after a word; the next call or wait_idle decides
  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] g,
                             input logic signed [SAMPLE_WIDTH-1:0] x);
    while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
      samp_if.valid <= 1'b0;
      @(posedge clk);
    end
    samp_if.valid         <= 1'b1;
    samp_if.gps_altitude  <= g;
    samp_if.prox_altitude <= x;
    @(posedge clk);
    while (!samp_if.ready) @(posedge clk);
    fused_q.push_back(predict_fused(g, x));
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_WIDTH-1:0] value);
    while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
      cfg_if.valid <= 1'b0;
      @(posedge clk);
    end
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_PROCESS_VAR: m_proc = value;
      REG_GPS_VAR:     m_gps = value;
      REG_PROX_VAR:    m_prox = value;
      default: ;
    endcase
  endtask

  task automatic set_noise(input logic [CFG_WIDTH-1:0] pv, input logic [CFG_WIDTH-1:0] gv,
                           input logic [CFG_WIDTH-1:0] xv, input bit poke_unused);
    write_reg(REG_PROCESS_VAR, pv);
    if (poke_unused) write_reg(REG_UNUSED, CFG_WIDTH'($urandom));
    write_reg(REG_GPS_VAR, gv);
    write_reg(REG_PROX_VAR, xv);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    samp_if.valid <= 1'b0;
    while (fused_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_altitude();
    logic signed [SAMPLE_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = ALT_MAX;
          1:       v = ALT_MIN;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      1, 2: v = $urandom;
      default: v = alt_track + int'($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
    return v;
  endfunction

  function automatic logic [CFG_WIDTH-1:0] pick_noise();
    logic [CFG_WIDTH-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = NOISE_MAX;
      2:       v = CFG_WIDTH'($urandom_range(1, 4095));
      3:       v = CFG_WIDTH'($urandom_range(1, 1 << 18));
      default: v = CFG_WIDTH'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_tracked_words(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) alt_track = $urandom;
      else alt_track = alt_track + int'($urandom_range(0, 1 << 18)) - (1 << 17);
      send_sample(pick_altitude(), pick_altitude());
    end
  endtask

  // first word seeds the estimate; max + min averages to -1 (floor)
  task automatic test_seed_extremes();
    send_sample(ALT_MAX, ALT_MIN);
    send_sample(ALT_MAX, ALT_MAX);
    send_sample(ALT_MIN, ALT_MIN);
    send_sample('0, '0);
    send_sample(ALT_MIN, ALT_MAX);
    send_sample('1, '0);
    send_sample(32'sd1, '1);
    send_sample(ALT_MAX, '0);
  endtask

  task automatic test_unused_index();
    wait_idle();
    set_noise(CFG_WIDTH'(1 << 12), m_gps, m_prox, 1'b1);
    send_sample(32'sd65536, 32'sd131072);
    send_sample(ALT_MIN, 32'sd65536);
    send_sample(ALT_MAX, ALT_MIN);
  endtask

  // gain clamps on zero noise, then P decays to zero and P + R is zero
  task automatic test_zero_noise();
    wait_idle();
    set_noise('0, '0, '0, 1'b0);
    send_sample(ALT_MAX, ALT_MIN);
    send_sample(ALT_MIN, ALT_MAX);
    send_sample(32'sd1000, 32'sd1000);
    send_sample('1, ALT_MAX);
    send_sample('0, '0);
  endtask

  task automatic test_max_noise();
    wait_idle();
    set_noise(NOISE_MAX, NOISE_MAX, NOISE_MAX, 1'b0);
    send_sample(ALT_MAX, ALT_MAX);
    send_sample(ALT_MIN, ALT_MIN);
    send_sample(ALT_MAX, ALT_MIN);
    send_sample(ALT_MIN, ALT_MAX);
    send_sample('0, '1);
  endtask

  task automatic test_min_noise();
    wait_idle();
    set_noise('0, CFG_WIDTH'(1), CFG_WIDTH'(1), 1'b0);
    send_sample(ALT_MAX, ALT_MIN);
    send_sample(32'sd5, -32'sd5);
    send_sample(ALT_MIN, ALT_MAX);
    send_sample('0, '0);
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      set_noise(pick_noise(), pick_noise(), pick_noise(), $urandom_range(0, 3) == 0);
      send_tracked_words(PHASE_WORDS);
    end
  endtask

  task automatic test_gapless_burst();
    wait_idle();
    set_noise(CFG_WIDTH'(655), CFG_WIDTH'(65536), CFG_WIDTH'(1638400), 1'b0);
    gaps_on = 1'b0;
    send_tracked_words(BURST_WORDS);
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) res_if.ready <= !gaps_on || ($urandom_range(0, 99) >= GAP_PCT);

  always @(posedge clk) begin : check_result
    fused_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (fused_q.size() == 0) begin
        report_fail("result word with none expected");
      end else begin
        want = fused_q.pop_front();
        if (res_if.altitude_estimate !== want.altitude_estimate)
          report_fail($sformatf("altitude_estimate exp %0d got %0d",
                                want.altitude_estimate, res_if.altitude_estimate));
        if (res_if.estimate_variance !== want.estimate_variance)
          report_fail($sformatf("estimate_variance exp %0d got %0d",
                                want.estimate_variance, res_if.estimate_variance));
      end
    end
  end

  always @(posedge clk) begin
    if ((samp_if.valid && samp_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    samp_if.valid = 1'b0;
    samp_if.gps_altitude = '0;
    samp_if.prox_altitude = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    m_proc = PROCESS_VAR_RST;
    m_gps = GPS_VAR_RST;
    m_prox = PROX_VAR_RST;
    m_est = '0;
    m_var = '0;
    m_started = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_seed_extremes();
    test_unused_index();
    test_zero_noise();
    test_max_noise();
    test_min_noise();
    test_random_phases();
    test_gapless_burst();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fused_q.size() != 0) report_fail("expected words left over");
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
